>>> rtl/core/dsm_pkg.sv
// Shared types and constants for the dot-star pattern matcher.
// No dependencies; every other file in rtl/core uses this package.
package dsm_pkg;

    localparam int FUNC_W          = 2;
    localparam int SYM_W           = 8;
    localparam int MAX_TOKENS_DEF  = 32;

    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [SYM_W-1:0]  t_sym;

    // Word function codes
    localparam t_func FUNC_CLEAR   = 2'd0;
    localparam t_func FUNC_PATTERN = 2'd1;
    localparam t_func FUNC_TEXT    = 2'd2;
    localparam t_func FUNC_END     = 2'd3;

    localparam t_sym DOT_BYTE  = 8'h2E;
    localparam t_sym STAR_BYTE = 8'h2A;

    // One decoded word, qualified by the processing stage firing
    typedef struct packed {
        logic clear;
        logic append;
        logic text;
        logic finish;
        t_sym symbol;
    } t_cmd;

endpackage

>>> rtl/core/dsm_if.sv
// Valid/ready channel interfaces for the dot-star pattern matcher.
// Depends on dsm_pkg for the payload types.
interface dsm_in_if;
    logic            valid;
    logic            ready;
    dsm_pkg::t_func  func;
    dsm_pkg::t_sym   symbol;

    modport source (output valid, output func, output symbol, input ready);
    modport sink   (input valid, input func, input symbol, output ready);
endinterface

interface dsm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

>>> rtl/core/dsm_token_store.sv
// Pattern token store: byte and starred bit per token, token count, overflow flag.
// Depends on dsm_pkg for the command struct and the special bytes.
module dsm_token_store #(
    parameter int MAX_TOKENS = dsm_pkg::MAX_TOKENS_DEF,
    parameter int CNT_W      = $clog2(MAX_TOKENS + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  dsm_pkg::t_cmd            i_cmd,
    output dsm_pkg::t_sym            o_token_byte [MAX_TOKENS],
    output logic [MAX_TOKENS-1:0]    o_token_star,
    output logic [MAX_TOKENS-1:0]    o_token_valid,
    output logic [CNT_W-1:0]         o_count,
    output logic                     o_overflow
);

    logic [CNT_W-1:0]        r_count,    n_count;
    logic                    r_overflow, n_overflow;
    logic                    r_last_star, n_last_star;
    dsm_pkg::t_sym           r_byte [MAX_TOKENS];
    logic [MAX_TOKENS-1:0]   r_star;

    logic             append_ok;
    logic             wr_star;
    logic             wr_new;
    logic             set_ovf;
    logic             full;
    logic [CNT_W-1:0] last_idx;

    assign full      = (r_count == CNT_W'(MAX_TOKENS));
    assign last_idx  = r_count - CNT_W'(1);
    assign append_ok = i_cmd.append && !r_overflow;
    // A star on an unstarred last token stars it; otherwise it is a literal
    assign wr_star   = append_ok && (i_cmd.symbol == dsm_pkg::STAR_BYTE) &&
                       (r_count != '0) && !r_last_star;
    assign wr_new    = append_ok && !wr_star && !full;
    assign set_ovf   = append_ok && !wr_star && full;

    always_comb begin
        n_count     = r_count;
        n_overflow  = r_overflow;
        n_last_star = r_last_star;
        if (i_cmd.clear) begin
            n_count     = '0;
            n_overflow  = 1'b0;
            n_last_star = 1'b0;
        end else if (wr_star) begin
            n_last_star = 1'b1;
        end else if (wr_new) begin
            n_count     = r_count + CNT_W'(1);
            n_last_star = 1'b0;
        end else if (set_ovf) begin
            n_overflow  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_last_star <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_overflow  <= n_overflow;
            r_last_star <= n_last_star;
        end
    end

    for (genvar j = 0; j < MAX_TOKENS; j++) begin : g_entry
        always_ff @(posedge i_clk) begin
            if (wr_new && (r_count == CNT_W'(j))) begin
                r_byte[j] <= i_cmd.symbol;
                r_star[j] <= 1'b0;
            end else if (wr_star && (last_idx == CNT_W'(j))) begin
                r_star[j] <= 1'b1;
            end
        end
        assign o_token_byte[j]  = r_byte[j];
        assign o_token_valid[j] = (CNT_W'(j) < r_count);
    end

    assign o_token_star = r_star;
    assign o_count      = r_count;
    assign o_overflow   = r_overflow;

endmodule

>>> rtl/core/dsm_nfa.sv
// Active-position vector with epsilon closure over starred tokens and text step.
// Depends on dsm_pkg; token data comes from dsm_token_store.
module dsm_nfa #(
    parameter int MAX_TOKENS = dsm_pkg::MAX_TOKENS_DEF,
    parameter int CNT_W      = $clog2(MAX_TOKENS + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  dsm_pkg::t_cmd            i_cmd,
    input  dsm_pkg::t_sym            i_token_byte [MAX_TOKENS],
    input  logic [MAX_TOKENS-1:0]    i_token_star,
    input  logic [MAX_TOKENS-1:0]    i_token_valid,
    input  logic [CNT_W-1:0]         i_count,
    output logic                     o_matched
);

    localparam int POS  = MAX_TOKENS + 1;
    localparam int LVLS = (POS > 1) ? $clog2(POS) : 1;

    logic [POS-1:0]        r_active, n_active;
    logic [POS-1:0]        gen  [LVLS+1];
    logic [POS-1:0]        prop [LVLS+1];
    logic [POS-1:0]        closed;
    logic [MAX_TOKENS-1:0] hit;
    logic [MAX_TOKENS-1:0] take;
    logic [POS-1:0]        stepped;

    // Closure is a carry chain: position i+1 inherits i through a starred
    // token; resolve it with a log-depth prefix.
    assign gen[0]  = r_active;
    assign prop[0] = {i_token_star & i_token_valid, 1'b0};

    for (genvar l = 0; l < LVLS; l++) begin : g_lvl
        for (genvar i = 0; i < POS; i++) begin : g_pos
            if (i >= (1 << l)) begin : g_mix
                assign gen[l+1][i]  = gen[l][i] | (prop[l][i] & gen[l][i-(1<<l)]);
                assign prop[l+1][i] = prop[l][i] & prop[l][i-(1<<l)];
            end else begin : g_pass
                assign gen[l+1][i]  = gen[l][i];
                assign prop[l+1][i] = prop[l][i];
            end
        end
    end

    assign closed = gen[LVLS];

    for (genvar j = 0; j < MAX_TOKENS; j++) begin : g_hit
        assign hit[j] = (i_token_byte[j] == dsm_pkg::DOT_BYTE) ||
                        (i_token_byte[j] == i_cmd.symbol);
    end

    assign take    = closed[MAX_TOKENS-1:0] & i_token_valid & hit;
    // Starred token stays in place, plain token advances one position
    assign stepped = {1'b0, take & i_token_star} | {take & ~i_token_star, 1'b0};

    assign o_matched = closed[i_count];

    always_comb begin
        n_active = r_active;
        if (i_cmd.clear || i_cmd.finish) begin
            n_active = POS'(1);
        end else if (i_cmd.text) begin
            n_active = stepped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= POS'(1);
        end else begin
            r_active <= n_active;
        end
    end

endmodule

>>> rtl/core/dot_star_pattern_matcher.sv
// Top level of the dot-star pattern matcher: input register, token store,
// NFA stage and result register. Depends on dsm_pkg, dsm_if, dsm_token_store, dsm_nfa.
//
//   channel  | dir | words                      | payload
//   ---------+-----+----------------------------+---------------------------
//   i_in     | in  | clear/pattern/text/end     | func[1:0], symbol[7:0]
//   o_out    | out | one per end-of-text word   | matched, pattern_overflow
//
// Every word is captured in the input register, then applied to the token store and
// active vector; one word per cycle sustained while no end-of-text word waits on a
// held result. An end-of-text result passes the input, then the result register.
// Reset (synchronous, active low) empties the pattern and sets position zero.
// A result held on o_out stalls only an end-of-text word behind it.
module dot_star_pattern_matcher #(
    parameter int MAX_TOKENS = dsm_pkg::MAX_TOKENS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dsm_in_if.sink         i_in,
    dsm_out_if.source      o_out
);

    localparam int CNT_W = $clog2(MAX_TOKENS + 1);

    logic                  r_in_valid, n_in_valid;
    dsm_pkg::t_func        r_func;
    dsm_pkg::t_sym         r_symbol;
    logic                  r_out_valid, n_out_valid;
    logic                  r_matched;
    logic                  r_ovf;

    logic                  out_free;
    logic                  fire;
    dsm_pkg::t_cmd         cmd;
    dsm_pkg::t_sym         token_byte [MAX_TOKENS];
    logic [MAX_TOKENS-1:0] token_star;
    logic [MAX_TOKENS-1:0] token_valid;
    logic [CNT_W-1:0]      count;
    logic                  overflow;
    logic                  matched;

    assign out_free   = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && ((r_func != dsm_pkg::FUNC_END) || out_free);
    assign i_in.ready = !r_in_valid || fire;

    always_comb begin
        cmd        = '0;
        cmd.symbol = r_symbol;
        if (fire) begin
            unique case (r_func)
                dsm_pkg::FUNC_CLEAR:   cmd.clear  = 1'b1;
                dsm_pkg::FUNC_PATTERN: cmd.append = 1'b1;
                dsm_pkg::FUNC_TEXT:    cmd.text   = 1'b1;
                dsm_pkg::FUNC_END:     cmd.finish = 1'b1;
                default:               cmd.clear  = 1'b0;
            endcase
        end
    end

    assign n_in_valid  = (i_in.valid && i_in.ready) || (r_in_valid && !fire);
    assign n_out_valid = cmd.finish || (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_func   <= i_in.func;
            r_symbol <= i_in.symbol;
        end
        if (cmd.finish) begin
            r_matched <= matched;
            r_ovf     <= overflow;
        end
    end

    dsm_token_store #(
        .MAX_TOKENS (MAX_TOKENS),
        .CNT_W      (CNT_W)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_token_byte  (token_byte),
        .o_token_star  (token_star),
        .o_token_valid (token_valid),
        .o_count       (count),
        .o_overflow    (overflow)
    );

    dsm_nfa #(
        .MAX_TOKENS (MAX_TOKENS),
        .CNT_W      (CNT_W)
    ) u_nfa (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_token_byte  (token_byte),
        .i_token_star  (token_star),
        .i_token_valid (token_valid),
        .i_count       (count),
        .o_matched     (matched)
    );

    assign o_out.valid            = r_out_valid;
    assign o_out.matched          = r_matched;
    assign o_out.pattern_overflow = r_ovf;

`ifndef NO_ASSERTIONS
    a_finish_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> r_out_valid && (r_ovf == $past(overflow)))
        else $error("end-of-text word did not load the result register");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CNT_W'(MAX_TOKENS))
        else $error("token count beyond capacity");

    a_overflow_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        overflow |-> (count == CNT_W'(MAX_TOKENS)))
        else $error("overflow flag set with free token slots");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |=> (count == '0) && !overflow)
        else $error("clear did not empty the pattern");
`endif

endmodule
